// File: design/oqsb_pkg.sv
`timescale 1ns / 1ps
// Shared codes and types for the output-queued switch buffer.
// No dependencies.
package oqsb_pkg;

  localparam int PortFieldWidth = 4;
  localparam int SendPortWidth  = 3;
  localparam int TagFieldWidth  = 16;
  localparam int OutcomeWidth   = 3;

  typedef enum logic [0:0] {
    REQ_ARRIVAL = 1'b0,
    REQ_DONE    = 1'b1
  } req_type_t;

  typedef enum logic [OutcomeWidth-1:0] {
    OUT_SENT    = 3'd0,
    OUT_QUEUED  = 3'd1,
    OUT_FULL    = 3'd2,
    OUT_BADPORT = 3'd3,
    OUT_IDLE    = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

// File: design/output_queued_switch_buffer_core.sv
`timescale 1ns / 1ps
// Output-queued switch buffer: per-port tag FIFOs in one shared tag memory.
// Depends on oqsb_pkg.
//
// Each item is an arrival or a transmission-done event for one output port
// and yields exactly one result item. Arrivals, drops, bad ports and
// done-on-empty events load their result from ST_IDLE; a done event that
// pops a FIFO loads it from ST_READ, after the registered tag memory read. Port state
// (busy flag, head, tail, fill count) sits in flip-flops cleared by reset;
// the tag memory holds NUM_PORTS*QUEUE_DEPTH entries and needs no clearing,
// since only written entries are ever read. A full FIFO drops the arrival
// (outcome 2); a negative or out-of-range port gives outcome 3.
module output_queued_switch_buffer_core #(
  parameter int NUM_PORTS   = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] port_number, [19:4] packet_tag, zero pad
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] send_port, [18:3] send_tag, zero pad
  output logic [3:0]  m_tuser    // [0] send_valid, [3:1] outcome
);
  import oqsb_pkg::*;

  localparam int SW = (TAG_WIDTH < TagFieldWidth) ? TAG_WIDTH : TagFieldWidth;
  localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);

  state_t state;

  logic [NUM_PORTS-1:0] busy;
  logic [IW-1:0]        head_idx [NUM_PORTS];
  logic [IW-1:0]        tail_idx [NUM_PORTS];
  logic [CW-1:0]        fill     [NUM_PORTS];

  logic [SW-1:0] tag_mem [MEM_DEPTH];
  logic [SW-1:0] mem_rdata;
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  logic                     out_send;
  logic [SendPortWidth-1:0] out_port;
  logic [TagFieldWidth-1:0] out_tag;
  outcome_t                 out_outcome;
  logic [SendPortWidth-1:0] rd_port;

  req_type_t                 req;
  logic [PortFieldWidth-1:0] port_raw;
  logic [TagFieldWidth-1:0]  tag_in;
  logic                      port_ok;
  logic [PW-1:0]             pidx;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty;
  logic [IW-1:0]             cur_idx;
  logic                      out_load;

  assign req      = req_type_t'(s_tuser[0]);
  assign port_raw = s_tdata[3:0];
  assign tag_in   = s_tdata[19:4];
  assign port_ok  = !port_raw[3] && (32'(port_raw[2:0]) < NUM_PORTS);
  assign pidx     = PW'(port_raw[2:0]);

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign is_full  = (fill[pidx] == CW'(QUEUE_DEPTH));
  assign is_empty = (fill[pidx] == '0);
  assign cur_idx  = (req == REQ_ARRIVAL) ? tail_idx[pidx] : head_idx[pidx];
  assign mem_addr = AW'(32'(pidx) * QUEUE_DEPTH + 32'(cur_idx));
  assign mem_we   = accept && port_ok && (req == REQ_ARRIVAL) && busy[pidx] && !is_full;

  // a popping done event loads the result in the cycle after acceptance, from ST_READ
  assign out_load = (state == ST_READ) ||
                    (accept && !(port_ok && (req == REQ_DONE) && !is_empty));

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_addr] <= tag_in[SW-1:0];
    end
    mem_rdata <= tag_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      busy     <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        head_idx[i] <= '0;
        tail_idx[i] <= '0;
        fill[i]     <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!port_ok) begin
              out_send    <= 1'b0;
              out_port    <= '0;
              out_tag     <= '0;
              out_outcome <= OUT_BADPORT;
            end else if (req == REQ_ARRIVAL) begin
              out_port <= port_raw[2:0];
              if (!busy[pidx]) begin
                busy[pidx]  <= 1'b1;
                out_send    <= 1'b1;
                out_tag     <= TagFieldWidth'(tag_in[SW-1:0]);
                out_outcome <= OUT_SENT;
              end else if (is_full) begin
                out_send    <= 1'b0;
                out_tag     <= '0;
                out_outcome <= OUT_FULL;
              end else begin
                tail_idx[pidx] <= next_slot(tail_idx[pidx]);
                fill[pidx]     <= fill[pidx] + 1'b1;
                out_send       <= 1'b0;
                out_tag        <= '0;
                out_outcome    <= OUT_QUEUED;
              end
            end else if (!is_empty) begin
              head_idx[pidx] <= next_slot(head_idx[pidx]);
              fill[pidx]     <= fill[pidx] - 1'b1;
              busy[pidx]     <= 1'b1;
              rd_port        <= port_raw[2:0];
              state          <= ST_READ;
            end else begin
              busy[pidx]  <= 1'b0;
              out_send    <= 1'b0;
              out_port    <= port_raw[2:0];
              out_tag     <= '0;
              out_outcome <= OUT_IDLE;
            end
          end
        end
        ST_READ: begin
          // tag memory data for the popped head is valid this cycle
          out_send    <= 1'b1;
          out_port    <= rd_port;
          out_tag     <= TagFieldWidth'(mem_rdata);
          out_outcome <= OUT_SENT;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {5'd0, out_tag, out_port};
  assign m_tuser = {out_outcome, out_send};

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for output_queued_switch_buffer_core: directed table, then random traffic, every result
// checked against the table's expected result or a per-port queue predictor. Depends on oqsb_pkg.
module tb_top;
  import oqsb_pkg::*;

  localparam int NumPorts   = 8;
  localparam int QueueDepth = 64;
  localparam int DirRows    = 22;
  localparam int RandItems  = 800;

  typedef struct packed {
    logic       send_valid;
    logic [2:0] send_port;
    logic [15:0] send_tag;
    outcome_t   outcome;
  } switch_result_t;

  typedef struct packed {
    bit             use_typed;
    switch_result_t want;
  } typed_exp_t;

  typedef struct packed {
    req_type_t      kind;
    logic [3:0]     port;
    logic [15:0]    tag;
    int             reps;
    bit             use_typed;
    switch_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;

  // predictor state
  bit          port_busy [NumPorts];
  logic [15:0] fifo_mem  [NumPorts][QueueDepth];
  int          fifo_head [NumPorts];
  int          fifo_tail [NumPorts];
  int          fifo_fill [NumPorts];

  switch_result_t pending_q [$];
  typed_exp_t     typed_q [$];
  int             mismatch_cnt = 0;
  int             burst_left = 0;
  int             rdy_mode = 0;
  int             rdy_left = 0;

  output_queued_switch_buffer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  stim_row_t dir_tab [DirRows] = '{
    '{REQ_DONE,    4'd0, 16'h0000,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_IDLE}},
    '{REQ_ARRIVAL, 4'd0, 16'hFFFF,  1, 1'b1, '{1'b1, 3'd0, 16'hFFFF, OUT_SENT}},
    '{REQ_ARRIVAL, 4'd0, 16'h0000,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_QUEUED}},
    '{REQ_ARRIVAL, 4'd7, 16'h8000,  1, 1'b1, '{1'b1, 3'd7, 16'h8000, OUT_SENT}},
    '{REQ_ARRIVAL, 4'd7, 16'h1234,  1, 1'b1, '{1'b0, 3'd7, 16'h0000, OUT_QUEUED}},
    '{REQ_DONE,    4'd0, 16'h0000,  1, 1'b0, '0},
    '{REQ_DONE,    4'd0, 16'hFFFF,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_IDLE}},
    '{REQ_DONE,    4'd0, 16'h0000,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_IDLE}},
    '{REQ_ARRIVAL, 4'hF, 16'hFFFF,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_BADPORT}},
    '{REQ_DONE,    4'hF, 16'h0000,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_BADPORT}},
    '{REQ_ARRIVAL, 4'h8, 16'h5555,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_BADPORT}},
    '{REQ_DONE,    4'h9, 16'hFFFF,  1, 1'b1, '{1'b0, 3'd0, 16'h0000, OUT_BADPORT}},
    '{REQ_ARRIVAL, 4'd3, 16'hAAAA,  1, 1'b1, '{1'b1, 3'd3, 16'hAAAA, OUT_SENT}},
    '{REQ_ARRIVAL, 4'd3, 16'h0100, 64, 1'b0, '0},
    '{REQ_ARRIVAL, 4'd3, 16'hBEEF,  1, 1'b1, '{1'b0, 3'd3, 16'h0000, OUT_FULL}},
    '{REQ_DONE,    4'd3, 16'h0000, 64, 1'b0, '0},
    '{REQ_DONE,    4'd3, 16'h0000,  1, 1'b1, '{1'b0, 3'd3, 16'h0000, OUT_IDLE}},
    '{REQ_ARRIVAL, 4'd3, 16'hFF00, 10, 1'b0, '0},
    '{REQ_DONE,    4'd7, 16'h0000,  1, 1'b0, '0},
    '{REQ_ARRIVAL, 4'd1, 16'h0001,  1, 1'b1, '{1'b1, 3'd1, 16'h0001, OUT_SENT}},
    '{REQ_DONE,    4'd1, 16'h0000,  1, 1'b1, '{1'b0, 3'd1, 16'h0000, OUT_IDLE}},
    '{REQ_ARRIVAL, 4'd6, 16'h7FFF,  1, 1'b1, '{1'b1, 3'd6, 16'h7FFF, OUT_SENT}}
  };

  function automatic switch_result_t switch_step(req_type_t kind, logic [3:0] port,
                                                 logic [15:0] tag);
    switch_result_t r;
    int p;
    r = '{1'b0, 3'd0, 16'h0000, OUT_BADPORT};
    if (port[3] || int'(port) >= NumPorts) return r;
    p = int'(port);
    r.send_port = port[2:0];
    if (kind == REQ_ARRIVAL) begin
      if (!port_busy[p]) begin
        port_busy[p] = 1'b1;
        r.send_valid = 1'b1;
        r.send_tag   = tag;
        r.outcome    = OUT_SENT;
      end else if (fifo_fill[p] >= QueueDepth) begin
        r.outcome = OUT_FULL;
      end else begin
        fifo_mem[p][fifo_tail[p]] = tag;
        fifo_tail[p] = (fifo_tail[p] + 1) % QueueDepth;
        fifo_fill[p]++;
        r.outcome = OUT_QUEUED;
      end
    end else if (fifo_fill[p] != 0) begin
      r.send_valid = 1'b1;
      r.send_tag   = fifo_mem[p][fifo_head[p]];
      r.outcome    = OUT_SENT;
      fifo_head[p] = (fifo_head[p] + 1) % QueueDepth;
      fifo_fill[p]--;
      port_busy[p] = 1'b1;
    end else begin
      port_busy[p] = 1'b0;
      r.outcome = OUT_IDLE;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // drive one item, hold until accepted, then maybe insert a gap
  task automatic push_event(req_type_t kind, logic [3:0] port, logic [15:0] tag,
                            bit use_typed, switch_result_t want);
    typed_exp_t te;
    te = '{use_typed, want};
    typed_q.insert(typed_q.size(), te);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, tag, port};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // receiver stall pattern: always ready, coin flip, or mostly stalled
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode <= $urandom_range(0, 2);
      rdy_left <= $urandom_range(16, 96);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // input acceptance feeds the predictor before output check in the same edge
  always @(posedge clk) begin
    typed_exp_t     te;
    switch_result_t pred, got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        te   = typed_q.pop_front();
        pred = switch_step(req_type_t'(s_tuser[0]), s_tdata[3:0], s_tdata[19:4]);
        pending_q.insert(pending_q.size(), te.use_typed ? te.want : pred);
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tuser[0], m_tdata[2:0], m_tdata[18:3], outcome_t'(m_tuser[3:1])};
        if (pending_q.size() == 0) begin
          report_mismatch("result with nothing expected", got.send_tag, 16'h0000);
        end else begin
          want = pending_q.pop_front();
          if (got.send_valid !== want.send_valid)
            report_mismatch("send_valid", 16'(got.send_valid), 16'(want.send_valid));
          if (got.send_port !== want.send_port)
            report_mismatch("send_port", 16'(got.send_port), 16'(want.send_port));
          if (got.send_tag !== want.send_tag)
            report_mismatch("send_tag", got.send_tag, want.send_tag);
          if (got.outcome !== want.outcome)
            report_mismatch("outcome", 16'(got.outcome), 16'(want.outcome));
        end
      end
    end
  end

  initial begin
    int          mode;
    int          block_left;
    int          hot;
    req_type_t   kind;
    logic [3:0]  port;
    logic [15:0] tag;
    mode = 0;
    block_left = 0;
    hot = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      for (int i = 0; i < dir_tab[r].reps; i++)
        push_event(dir_tab[r].kind, dir_tab[r].port, dir_tab[r].tag + 16'(i),
                   dir_tab[r].use_typed, dir_tab[r].want);
    end

    for (int n = 0; n < RandItems; n++) begin
      // blocks of traffic: fill one port, mixed, or drain-heavy
      if (block_left == 0) begin
        mode = $urandom_range(0, 2);
        block_left = (mode == 0) ? 100 : 50;
        hot = $urandom_range(0, NumPorts - 1);
      end
      block_left--;
      case (mode)
        0: kind = ($urandom_range(0, 9) < 9) ? REQ_ARRIVAL : REQ_DONE;
        1: kind = ($urandom_range(0, 1) == 0) ? REQ_ARRIVAL : REQ_DONE;
        default: kind = ($urandom_range(0, 3) == 0) ? REQ_ARRIVAL : REQ_DONE;
      endcase
      port = (mode == 0) ? 4'(hot) : 4'($urandom_range(0, NumPorts - 1));
      if ($urandom_range(0, 24) == 0) port = 4'($urandom_range(NumPorts, 15));
      tag = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 15) == 0) tag = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      if (n == RandItems / 2) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
      end
      push_event(kind, port, tag, 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TIMEOUT with %0d results outstanding", pending_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
design/oqsb_pkg.sv
design/output_queued_switch_buffer_core.sv
tb/tb_top.sv
